>>> src/rcnl_pkg.sv
`timescale 1ns / 1ps

package rcnl_pkg;

    // Fixed widths of the request, result and configuration fields.
    localparam int ROW_W   = 16;
    localparam int CNT_W   = 32;
    localparam int RC_W    = 17;

    localparam logic [RC_W-1:0]  RC_RESET  = 17'h10000;
    localparam logic [CNT_W-1:0] CNT_MAX   = 32'hFFFF_FFFF;

    // Request codes.
    localparam logic REQ_ACCESS    = 1'b0;
    localparam logic REQ_NEW_IMAGE = 1'b1;

    // The line index takes two steps: a reciprocal multiply for the quotient,
    // then the remainder from a constant multiply and a subtract.
    localparam int MOD_DIGITS = 2;
    localparam int MOD_DIG_W  = (MOD_DIGITS > 1) ? $clog2(MOD_DIGITS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_DEMAND,
        ST_PREFETCH,
        ST_FLUSH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                 capture;
        logic                 mod_step;
        logic [MOD_DIG_W-1:0] mod_digit;
        logic                 demand;
        logic                 prefetch;
        logic                 flush;
        logic                 load;
    } cmd_t;

    typedef struct packed {
        logic pf_ok;
    } stat_t;

endpackage

>>> src/rcnl_ram.sv
`timescale 1ns / 1ps

module rcnl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 3
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: a read and a write to the same entry return the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/rcnl_ctrl.sv
`timescale 1ns / 1ps

module rcnl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              req_type,
    output logic              out_valid,
    input  logic              out_stall,
    input  rcnl_pkg::stat_t   stat,
    output rcnl_pkg::cmd_t    cmd
);

    rcnl_pkg::state_t                 state_reg;
    rcnl_pkg::state_t                 state_next;
    logic [rcnl_pkg::MOD_DIG_W-1:0]   digit_reg;
    logic [rcnl_pkg::MOD_DIG_W-1:0]   digit_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             mod_last;

    assign mod_last = (digit_reg == rcnl_pkg::MOD_DIG_W'(rcnl_pkg::MOD_DIGITS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcnl_pkg::ST_IDLE;
            digit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            digit_reg     <= digit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        digit_next     = digit_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.mod_digit  = digit_reg;
        in_stall       = 1'b1;

        unique case (state_reg)
            rcnl_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    digit_next  = '0;
                    if (req_type == rcnl_pkg::REQ_NEW_IMAGE)
                    begin
                        state_next = rcnl_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        state_next = rcnl_pkg::ST_MOD;
                    end
                end
            end
            rcnl_pkg::ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (mod_last)
                begin
                    digit_next = '0;
                    state_next = rcnl_pkg::ST_DEMAND;
                end
                else
                begin
                    digit_next = digit_reg + 1'b1;
                end
            end
            rcnl_pkg::ST_DEMAND:
            begin
                cmd.demand = 1'b1;
                if (stat.pf_ok)
                begin
                    state_next = rcnl_pkg::ST_PREFETCH;
                end
                else
                begin
                    state_next = rcnl_pkg::ST_FINISH;
                end
            end
            rcnl_pkg::ST_PREFETCH:
            begin
                cmd.prefetch = 1'b1;
                state_next   = rcnl_pkg::ST_FINISH;
            end
            rcnl_pkg::ST_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = rcnl_pkg::ST_FINISH;
            end
            rcnl_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = rcnl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rcnl_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> src/rcnl_datapath.sv
`timescale 1ns / 1ps

module rcnl_datapath #(
    parameter int NUM_LINES = 3,
    parameter int ROW_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rcnl_pkg::cmd_t                cmd,
    output rcnl_pkg::stat_t               stat,
    input  logic [rcnl_pkg::ROW_W-1:0]    row_index,
    input  logic                          cfg_we,
    input  logic [rcnl_pkg::RC_W-1:0]     cfg_wdata,
    output logic                          demand_hit,
    output logic                          prefetch_issued,
    output logic                          prefetch_hit,
    output logic [rcnl_pkg::CNT_W-1:0]    hits_total,
    output logic [rcnl_pkg::CNT_W-1:0]    misses_total
);

    localparam int SLOT_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int TAG_W  = (ROW_BITS < rcnl_pkg::ROW_W) ? ROW_BITS : rcnl_pkg::ROW_W;
    localparam logic [rcnl_pkg::ROW_W-1:0] ROW_MASK = (ROW_BITS >= rcnl_pkg::ROW_W) ?
        16'hFFFF : 16'((1 << ROW_BITS) - 1);
    localparam int unsigned SPAN_INT = (ROW_BITS >= rcnl_pkg::RC_W) ?
        131071 : (1 << ROW_BITS);
    localparam logic [rcnl_pkg::RC_W-1:0] SPAN_CLIP = 17'(SPAN_INT);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_LINES - 1);

    // Reciprocal of the line count, exact for every row of ROW_W bits.
    localparam int LINE_BITS = $clog2(NUM_LINES);
    localparam int RECIP_SH  = rcnl_pkg::ROW_W + LINE_BITS;
    localparam int PROD_W    = 2 * rcnl_pkg::ROW_W + 1;
    localparam logic [rcnl_pkg::ROW_W:0] RECIP = (rcnl_pkg::ROW_W + 1)'(
        ((longint'(1) << RECIP_SH) + longint'(NUM_LINES) - 1) / longint'(NUM_LINES));
    localparam logic [rcnl_pkg::ROW_W-1:0] LINES_ROW = (rcnl_pkg::ROW_W)'(NUM_LINES);

    // Control state.
    logic [rcnl_pkg::RC_W-1:0]  row_count_reg;
    logic [NUM_LINES-1:0]       valid_reg;
    logic [NUM_LINES-1:0]       valid_next;
    logic [rcnl_pkg::CNT_W-1:0] hit_cnt_reg;
    logic [rcnl_pkg::CNT_W-1:0] hit_cnt_next;
    logic [rcnl_pkg::CNT_W-1:0] miss_cnt_reg;
    logic [rcnl_pkg::CNT_W-1:0] miss_cnt_next;

    // Working payload.
    logic [rcnl_pkg::ROW_W-1:0] row_reg;
    logic [rcnl_pkg::ROW_W-1:0] quot_reg;
    logic [SLOT_W-1:0]          rem_reg;
    logic                       dh_reg;
    logic                       pi_reg;
    logic                       ph_reg;
    logic                       dh_out_reg;
    logic                       pi_out_reg;
    logic                       ph_out_reg;
    logic [rcnl_pkg::CNT_W-1:0] hits_out_reg;
    logic [rcnl_pkg::CNT_W-1:0] misses_out_reg;

    logic [PROD_W-1:0]            recip_prod;
    logic [rcnl_pkg::ROW_W-1:0]   quot_calc;
    logic [rcnl_pkg::ROW_W-1:0]   quot_mul;
    logic [rcnl_pkg::ROW_W-1:0]   rem_full;
    logic [SLOT_W-1:0]            rem_acc;
    logic [SLOT_W-1:0]            pf_slot;
    logic [rcnl_pkg::RC_W-1:0]    next_row;
    logic [rcnl_pkg::RC_W-1:0]    bound;
    logic [TAG_W-1:0]             row_tag;
    logic [TAG_W-1:0]             next_tag;
    logic [TAG_W-1:0]             rd_tag;
    logic [TAG_W-1:0]             pf_tag;
    logic                         dem_hit;
    logic                         pf_hit;
    logic                         hit_inc;
    logic                         miss_inc;
    logic                         ram_we;
    logic [SLOT_W-1:0]            ram_waddr;
    logic [TAG_W-1:0]             ram_wdata;
    logic [SLOT_W-1:0]            ram_raddr;

    // The first step registers row / NUM_LINES from a reciprocal multiply; the
    // second takes the remainder, which is the line index.
    assign recip_prod = PROD_W'(row_reg) * PROD_W'(RECIP);
    assign quot_calc  = (rcnl_pkg::ROW_W)'(recip_prod >> RECIP_SH);
    assign quot_mul   = quot_reg * LINES_ROW;
    assign rem_full   = row_reg - quot_mul;
    assign rem_acc    = rem_full[SLOT_W-1:0];

    assign pf_slot  = (rem_reg == LAST_SLOT) ? '0 : rem_reg + 1'b1;
    assign next_row = {1'b0, row_reg} + 17'd1;
    assign bound    = (row_count_reg < SPAN_CLIP) ? row_count_reg : SPAN_CLIP;
    assign stat.pf_ok = (next_row < bound);

    assign row_tag  = row_reg[TAG_W-1:0];
    assign next_tag = next_row[TAG_W-1:0];

    // With a single line the prefetch reads the entry the demand access just
    // settled, and that entry then holds the requested row.
    assign pf_tag  = (pf_slot == rem_reg) ? row_tag : rd_tag;
    assign dem_hit = valid_reg[rem_reg] && (rd_tag == row_tag);
    assign pf_hit  = valid_reg[pf_slot] && (pf_tag == next_tag);

    assign hit_inc  = (cmd.demand && dem_hit) || (cmd.prefetch && pf_hit);
    assign miss_inc = (cmd.demand && !dem_hit) || (cmd.prefetch && !pf_hit);

    assign ram_we    = miss_inc;
    assign ram_waddr = cmd.prefetch ? pf_slot : rem_reg;
    assign ram_wdata = cmd.prefetch ? next_tag : row_tag;
    assign ram_raddr = cmd.demand ? pf_slot : rem_acc;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.flush)
        begin
            valid_next = '0;
        end
        else if (cmd.demand && !dem_hit)
        begin
            valid_next[rem_reg] = 1'b1;
        end
        else if (cmd.prefetch && !pf_hit)
        begin
            valid_next[pf_slot] = 1'b1;
        end
    end

    assign hit_cnt_next  = (hit_inc && hit_cnt_reg != rcnl_pkg::CNT_MAX) ?
                           hit_cnt_reg + 1'b1 : hit_cnt_reg;
    assign miss_cnt_next = (miss_inc && miss_cnt_reg != rcnl_pkg::CNT_MAX) ?
                           miss_cnt_reg + 1'b1 : miss_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= rcnl_pkg::RC_RESET;
            valid_reg     <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                row_count_reg <= cfg_wdata;
            end
            valid_reg    <= valid_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_reg <= row_index & ROW_MASK;
            rem_reg <= '0;
            dh_reg  <= 1'b0;
            pi_reg  <= 1'b0;
            ph_reg  <= 1'b0;
        end
        if (cmd.mod_step)
        begin
            if (cmd.mod_digit == '0)
            begin
                quot_reg <= quot_calc;
            end
            else
            begin
                rem_reg <= rem_acc;
            end
        end
        if (cmd.demand)
        begin
            dh_reg <= dem_hit;
        end
        if (cmd.prefetch)
        begin
            pi_reg <= 1'b1;
            ph_reg <= pf_hit;
        end
        if (cmd.load)
        begin
            dh_out_reg     <= dh_reg;
            pi_out_reg     <= pi_reg;
            ph_out_reg     <= ph_reg;
            hits_out_reg   <= hit_cnt_reg;
            misses_out_reg <= miss_cnt_reg;
        end
    end

    rcnl_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_LINES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_tag)
    );

    assign demand_hit      = dh_out_reg;
    assign prefetch_issued = pi_out_reg;
    assign prefetch_hit    = ph_out_reg;
    assign hits_total      = hits_out_reg;
    assign misses_total    = misses_out_reg;

endmodule

>>> src/row_cache_next_line_prefetch.sv
// Tag-only direct-mapped row cache with next-row prefetch.
// Requests arrive on the input channel (in_valid, in_stall, req_type, row_index);
// each accepted beat produces exactly one result beat on the output channel
// (out_valid, out_stall, demand_hit, prefetch_issued, prefetch_hit, hits_total,
// misses_total). The row_count register is written through cfg_we/cfg_wdata and
// should only change while no request is in flight.
// An access request first finds its line index (a reciprocal multiply for the
// quotient, then the remainder), then does the demand lookup and, when row+1
// is inside the image, the prefetch lookup, both through the single tag RAM.
// The result register loads in the finish state once the output register is
// free; a new-image request clears all valid bits and then loads its result
// the same way.
// The next request is taken the cycle after the result loads, so requests are
// handled one at a time.
// The result sits in an output register, so a new request is accepted while a
// stalled result waits; that request then holds in its last step until the
// output register is free, and a stalled result beat does not change.
// Reset clears all valid bits and both counters and sets row_count to 65536.
`timescale 1ns / 1ps

module row_cache_next_line_prefetch #(
    parameter int NUM_LINES = 3,
    parameter int ROW_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [15:0] row_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        demand_hit,
    output logic        prefetch_issued,
    output logic        prefetch_hit,
    output logic [31:0] hits_total,
    output logic [31:0] misses_total,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata
);

    // Sequencer commands and datapath status.
    rcnl_pkg::cmd_t  cmd;
    rcnl_pkg::stat_t stat;

    rcnl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Tag RAM, valid bits, saturating counters and the result register.
    rcnl_datapath #(
        .NUM_LINES (NUM_LINES),
        .ROW_BITS  (ROW_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .row_index       (row_index),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .demand_hit      (demand_hit),
        .prefetch_issued (prefetch_issued),
        .prefetch_hit    (prefetch_hit),
        .hits_total      (hits_total),
        .misses_total    (misses_total)
    );

endmodule
